// ===== design/fttrk_pkg.sv =====
// ----------------------------------------------------------------------------
// fttrk_pkg
// Shared types and constants for the first-touch page tracker.
// ----------------------------------------------------------------------------
package fttrk_pkg;

    // fixed field widths
    localparam int ADDR_BITS        = 64;
    localparam int PAGE_NUMBER_BITS = 52;
    localparam int WORD_BITS        = 64;
    localparam int BIT_SEL_BITS     = 6;

    // parameter defaults
    localparam int DEF_REGION_SLOTS    = 16;
    localparam int DEF_REGION_TAG_BITS = 41;
    localparam int DEF_PAGE_SHIFT      = 12;

    // control states of the top level
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } fttrk_state_t;

    // region lookup status from the tag table
    typedef struct packed {
        logic hit;
        logic full;
    } fttrk_lookup_t;

endpackage

// ===== design/fttrk_tag_table.sv =====
// ----------------------------------------------------------------------------
// fttrk_tag_table
// Region tag registers with parallel compare and in-order slot allocation.
// ----------------------------------------------------------------------------
module fttrk_tag_table #(
    parameter int REGION_SLOTS    = fttrk_pkg::DEF_REGION_SLOTS,
    parameter int REGION_TAG_BITS = fttrk_pkg::DEF_REGION_TAG_BITS,
    localparam int SLOT_BITS      = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1,
    localparam int USED_BITS      = $clog2(REGION_SLOTS + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [REGION_TAG_BITS-1:0] lookup_tag,
    input  logic                       alloc_en,
    output logic [SLOT_BITS-1:0]       slot,
    output fttrk_pkg::fttrk_lookup_t   status
);

    logic [REGION_TAG_BITS-1:0] tags_reg [REGION_SLOTS];
    logic [USED_BITS-1:0]       used_reg;
    logic [USED_BITS-1:0]       used_next;
    logic                       hit;
    logic [SLOT_BITS-1:0]       hit_slot;

    // parallel compare over the allocated slots, lowest slot wins
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = REGION_SLOTS - 1; i >= 0; i--) begin
            if ((USED_BITS'(i) < used_reg) && (tags_reg[i] == lookup_tag)) begin
                hit      = 1'b1;
                hit_slot = SLOT_BITS'(i);
            end
        end
    end

    assign status.hit  = hit;
    assign status.full = (used_reg == USED_BITS'(REGION_SLOTS));
    assign slot        = hit ? hit_slot : used_reg[SLOT_BITS-1:0];

    // fill count of the table
    always_comb begin
        used_next = used_reg;
        if (alloc_en) begin
            used_next = used_reg + USED_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else begin
            used_reg <= used_next;
        end
    end

    // tag write on allocation
    always_ff @(posedge aclk) begin
        if (alloc_en) begin
            tags_reg[used_reg[SLOT_BITS-1:0]] <= lookup_tag;
        end
    end

endmodule

// ===== design/first_touch_page_tracker.sv =====
// ----------------------------------------------------------------------------
// first_touch_page_tracker
// Tracks which pages of known address regions have been touched and reports
// the page number on the first access to each page.
// ----------------------------------------------------------------------------
// Usage: one byte address enters per request on the s_ channel (s_valid,
// s_ready, s_address). Each request gives exactly one result on the m_
// channel: m_new_page with m_page_number on a first touch, or
// m_table_overflow when the region table is full and the region is new.
// The request is registered when taken, looked up in ST_LOOKUP, and its
// result is registered in ST_UPDATE. The bitmap memory is updated by
// read-modify-write (read with tag compare in ST_LOOKUP, write in ST_UPDATE).
// Requests are handled one at a time; the next one is taken in the write
// cycle of the current one, so a write always lands before the next read.
// Reset: aresetn clears the region table and starts a clearing pass over
// the bitmap memory, one word per cycle; s_ready stays low until it ends.
// Stall: the result sits in an output register; while m_ready is low and a
// result is held, at most one more request is taken and looked up, then the
// block waits in its write cycle with s_ready low.
// ----------------------------------------------------------------------------
module first_touch_page_tracker #(
    parameter int REGION_SLOTS    = fttrk_pkg::DEF_REGION_SLOTS,
    parameter int REGION_TAG_BITS = fttrk_pkg::DEF_REGION_TAG_BITS,
    parameter int PAGE_SHIFT      = fttrk_pkg::DEF_PAGE_SHIFT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [fttrk_pkg::ADDR_BITS-1:0]        s_address,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_new_page,
    output logic [fttrk_pkg::PAGE_NUMBER_BITS-1:0] m_page_number,
    output logic                                   m_table_overflow
);

    localparam int SLOT_BITS       = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int PAGE_INDEX_BITS = fttrk_pkg::ADDR_BITS - REGION_TAG_BITS - PAGE_SHIFT;
    localparam longint unsigned BITMAP_WORDS =
        (longint'(REGION_SLOTS) * (longint'(1) << PAGE_INDEX_BITS) + 63) / 64;
    localparam int WORD_ADDR_BITS  = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int BIT_ADDR_BITS   = SLOT_BITS + PAGE_INDEX_BITS;
    localparam int WB              = fttrk_pkg::WORD_BITS;
    localparam int BS              = fttrk_pkg::BIT_SEL_BITS;

    fttrk_pkg::fttrk_state_t state_reg, state_next;

    logic [fttrk_pkg::ADDR_BITS-1:0]        addr_reg;
    logic [WORD_ADDR_BITS-1:0]              clear_cnt_reg, clear_cnt_next;
    logic [WORD_ADDR_BITS-1:0]              word_addr_reg;
    logic [BS-1:0]                          bit_sel_reg;
    logic                                   overflow_reg;
    logic                                   m_valid_reg, m_valid_next;
    logic                                   m_new_page_reg;
    logic [fttrk_pkg::PAGE_NUMBER_BITS-1:0] m_page_number_reg;
    logic                                   m_table_overflow_reg;

    logic [WB-1:0]                          bitmap_mem [BITMAP_WORDS];
    logic [WB-1:0]                          rd_data_reg;

    logic                                   accept;
    logic                                   update_go;
    logic                                   lookup_en;
    logic                                   alloc_en;
    logic                                   first_touch;
    logic                                   wr_en;
    logic [WORD_ADDR_BITS-1:0]              wr_addr;
    logic [WB-1:0]                          wr_data;
    logic [WB-1:0]                          set_mask;
    logic [fttrk_pkg::ADDR_BITS-1:0]        shifted_addr;
    logic [BIT_ADDR_BITS-1:0]               bit_addr;
    logic [SLOT_BITS-1:0]                   slot;
    fttrk_pkg::fttrk_lookup_t               lookup;

    // region table
    fttrk_tag_table #(
        .REGION_SLOTS    (REGION_SLOTS),
        .REGION_TAG_BITS (REGION_TAG_BITS)
    ) u_tag_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .lookup_tag (addr_reg[fttrk_pkg::ADDR_BITS-1 -: REGION_TAG_BITS]),
        .alloc_en   (alloc_en),
        .slot       (slot),
        .status     (lookup)
    );

    // bit address of the page within the concatenated bitmap
    assign bit_addr = {slot, addr_reg[PAGE_SHIFT +: PAGE_INDEX_BITS]};

    // handshake and control outputs
    always_comb begin
        update_go   = (state_reg == fttrk_pkg::ST_UPDATE) && (!m_valid_reg || m_ready);
        s_ready     = (state_reg == fttrk_pkg::ST_IDLE) || update_go;
        accept      = s_valid && s_ready;
        lookup_en   = (state_reg == fttrk_pkg::ST_LOOKUP);
        alloc_en    = lookup_en && !lookup.hit && !lookup.full;
        set_mask    = WB'(1) << bit_sel_reg;
        first_touch = !overflow_reg && ((rd_data_reg & set_mask) == '0);
        wr_en       = (state_reg == fttrk_pkg::ST_CLEAR) || (update_go && first_touch);
        if (state_reg == fttrk_pkg::ST_CLEAR) begin
            wr_addr = clear_cnt_reg;
            wr_data = '0;
        end else begin
            wr_addr = word_addr_reg;
            wr_data = rd_data_reg | set_mask;
        end
        shifted_addr = addr_reg >> PAGE_SHIFT;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fttrk_pkg::ST_CLEAR: begin
                if (clear_cnt_reg == WORD_ADDR_BITS'(BITMAP_WORDS - 1)) begin
                    state_next = fttrk_pkg::ST_IDLE;
                end
            end
            fttrk_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = fttrk_pkg::ST_LOOKUP;
                end
            end
            fttrk_pkg::ST_LOOKUP: begin
                state_next = fttrk_pkg::ST_UPDATE;
            end
            fttrk_pkg::ST_UPDATE: begin
                if (update_go) begin
                    state_next = accept ? fttrk_pkg::ST_LOOKUP : fttrk_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fttrk_pkg::ST_IDLE;
            end
        endcase
    end

    // clear counter and output valid
    always_comb begin
        clear_cnt_next = clear_cnt_reg;
        if (state_reg == fttrk_pkg::ST_CLEAR) begin
            clear_cnt_next = clear_cnt_reg + WORD_ADDR_BITS'(1);
        end
        m_valid_next = m_valid_reg;
        if (update_go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fttrk_pkg::ST_CLEAR;
            clear_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // request capture and lookup results
    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg <= s_address;
        end
        if (lookup_en) begin
            word_addr_reg <= bit_addr[BS +: WORD_ADDR_BITS];
            bit_sel_reg   <= bit_addr[BS-1:0];
            overflow_reg  <= !lookup.hit && lookup.full;
        end
    end

    // bitmap memory, one read and one write port
    always_ff @(posedge aclk) begin
        if (lookup_en) begin
            rd_data_reg <= bitmap_mem[bit_addr[BS +: WORD_ADDR_BITS]];
        end
        if (wr_en) begin
            bitmap_mem[wr_addr] <= wr_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (update_go) begin
            m_new_page_reg       <= first_touch;
            m_table_overflow_reg <= overflow_reg;
            if (first_touch) begin
                m_page_number_reg <= shifted_addr[fttrk_pkg::PAGE_NUMBER_BITS-1:0];
            end else begin
                m_page_number_reg <= '0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_new_page       = m_new_page_reg;
    assign m_page_number    = m_page_number_reg;
    assign m_table_overflow = m_table_overflow_reg;

endmodule
